FILE: sv/twi_stc_pkg.sv
// ----------------------------------------------------------------------------
// twi_stc_pkg
// Types and codes shared by the two-wire slave transaction controller.
// ----------------------------------------------------------------------------
package twi_stc_pkg;

    localparam int unsigned CountWidth = 8;
    localparam int unsigned InDataWidth = 16;
    localparam int unsigned OutDataWidth = 32;

    typedef logic [CountWidth-1:0] count_t;

    typedef enum logic [1:0] {
        CMD_NONE          = 2'd0,
        CMD_RESPOND       = 2'd1,
        CMD_COMPLETE      = 2'd2,
        CMD_NACK_COMPLETE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_UNKNOWN   = 3'd0,
        RES_OK        = 3'd1,
        RES_BUS_ERROR = 3'd2,
        RES_COLLISION = 3'd3,
        RES_OVERFLOW  = 3'd4,
        RES_FAIL      = 3'd5
    } result_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_TRANSMIT = 2'd1,
        MODE_RECEIVE  = 2'd2
    } mode_t;

    // one slave status event
    typedef struct packed {
        logic   bus_error;
        logic   addr_or_stop;
        logic   addr_match;
        logic   data_event;
        logic   collision;
        logic   master_reads;
        logic   master_nacked;
        logic   clock_held;
        count_t tx_length;
    } event_t;

    // one result
    typedef struct packed {
        cmd_t    bus_command;
        logic    clear_addr_flag;
        count_t  buffer_index;
        logic    rx_store;
        logic    tx_load;
        logic    notify_receive;
        count_t  notify_count;
        logic    busy_res;
        result_t result_code;
        mode_t   mode;
    } result_item_t;

endpackage

FILE: sv/twi_stc_in_reg.sv
// ----------------------------------------------------------------------------
// twi_stc_in_reg
// Input register holding one accepted status event until it is processed.
// ----------------------------------------------------------------------------
module twi_stc_in_reg
    import twi_stc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  event_t in_event,
    output logic   in_ready,
    input  logic   advance,
    output logic   evt_valid,
    output event_t evt
);

    logic   valid_reg;
    logic   valid_next;
    event_t evt_reg;

    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            evt_reg <= in_event;
        end
    end

    assign evt_valid = valid_reg;
    assign evt = evt_reg;

endmodule

FILE: sv/twi_stc_event_logic.sv
// ----------------------------------------------------------------------------
// twi_stc_event_logic
// Transaction state and the per-event decision logic.
// ----------------------------------------------------------------------------
module twi_stc_event_logic
    import twi_stc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  count_t       cfg_wdata,
    input  logic         advance,
    input  event_t       evt,
    output result_item_t res
);

    count_t  rx_capacity_reg;
    count_t  received_count_reg, received_count_next;
    count_t  sent_count_reg, sent_count_next;
    count_t  send_limit_reg, send_limit_next;
    logic    receive_pending_reg, receive_pending_next;
    logic    busy_reg, busy_next;
    result_t result_reg, result_next;
    mode_t   mode_reg, mode_next;

    always_comb begin
        received_count_next  = received_count_reg;
        sent_count_next      = sent_count_reg;
        send_limit_next      = send_limit_reg;
        receive_pending_next = receive_pending_reg;
        busy_next            = busy_reg;
        result_next          = result_reg;
        mode_next            = mode_reg;

        res.bus_command     = CMD_NONE;
        res.clear_addr_flag = 1'b0;
        res.buffer_index    = '0;
        res.rx_store        = 1'b0;
        res.tx_load         = 1'b0;
        res.notify_receive  = 1'b0;
        res.notify_count    = '0;

        if (evt.bus_error) begin
            received_count_next = '0;
            sent_count_next     = '0;
            send_limit_next     = '0;
            busy_next           = 1'b0;
            result_next         = RES_BUS_ERROR;
            mode_next           = MODE_IDLE;
        end else if (evt.addr_or_stop) begin
            if (receive_pending_reg) begin
                res.notify_receive   = 1'b1;
                res.notify_count     = received_count_reg;
                receive_pending_next = 1'b0;
            end
            res.clear_addr_flag = !evt.addr_match;
            // stop with clock held still serves the missed address match
            if (evt.addr_match || evt.clock_held) begin
                busy_next       = 1'b1;
                result_next     = RES_UNKNOWN;
                res.bus_command = CMD_RESPOND;
                if (evt.master_reads) begin
                    sent_count_next = '0;
                    send_limit_next = evt.tx_length;
                    mode_next       = MODE_TRANSMIT;
                end else begin
                    received_count_next  = '0;
                    receive_pending_next = 1'b1;
                    mode_next            = MODE_RECEIVE;
                end
            end else begin
                busy_next   = 1'b0;
                result_next = RES_OK;
                mode_next   = MODE_IDLE;
            end
        end else if (evt.data_event) begin
            if (evt.collision) begin
                received_count_next = '0;
                sent_count_next     = '0;
                send_limit_next     = '0;
                busy_next           = 1'b0;
                result_next         = RES_COLLISION;
                mode_next           = MODE_IDLE;
            end else if (evt.master_reads) begin
                // nack before any byte counts as an ack
                if (sent_count_reg != '0 && evt.master_nacked) begin
                    res.bus_command = CMD_COMPLETE;
                    busy_next       = 1'b0;
                    result_next     = RES_OK;
                    mode_next       = MODE_IDLE;
                end else if (sent_count_reg < send_limit_reg) begin
                    res.buffer_index = sent_count_reg;
                    res.tx_load      = 1'b1;
                    sent_count_next  = sent_count_reg + 1'b1;
                    res.bus_command  = CMD_RESPOND;
                end else begin
                    res.bus_command = CMD_COMPLETE;
                    busy_next       = 1'b0;
                    result_next     = RES_OVERFLOW;
                    mode_next       = MODE_IDLE;
                end
            end else begin
                if (received_count_reg < rx_capacity_reg) begin
                    res.buffer_index    = received_count_reg;
                    res.rx_store        = 1'b1;
                    received_count_next = received_count_reg + 1'b1;
                    res.bus_command     = CMD_RESPOND;
                end else begin
                    res.bus_command = CMD_NACK_COMPLETE;
                    busy_next       = 1'b0;
                    result_next     = RES_OVERFLOW;
                    mode_next       = MODE_IDLE;
                end
            end
        end else begin
            busy_next   = 1'b0;
            result_next = RES_FAIL;
            mode_next   = MODE_IDLE;
        end

        res.busy_res    = busy_next;
        res.result_code = result_next;
        res.mode        = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_capacity_reg     <= '0;
            received_count_reg  <= '0;
            sent_count_reg      <= '0;
            send_limit_reg      <= '0;
            receive_pending_reg <= 1'b0;
            busy_reg            <= 1'b0;
            result_reg          <= RES_UNKNOWN;
            mode_reg            <= MODE_IDLE;
        end else begin
            if (cfg_we) begin
                rx_capacity_reg <= cfg_wdata;
            end
            if (advance) begin
                received_count_reg  <= received_count_next;
                sent_count_reg      <= sent_count_next;
                send_limit_reg      <= send_limit_next;
                receive_pending_reg <= receive_pending_next;
                busy_reg            <= busy_next;
                result_reg          <= result_next;
                mode_reg            <= mode_next;
            end
        end
    end

endmodule

FILE: sv/twi_stc_out_reg.sv
// ----------------------------------------------------------------------------
// twi_stc_out_reg
// Result register towards the master-side stream.
// ----------------------------------------------------------------------------
module twi_stc_out_reg
    import twi_stc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         evt_valid,
    input  result_item_t res_in,
    output logic         advance,
    output logic         out_valid,
    input  logic         out_ready,
    output result_item_t res_out
);

    logic         valid_reg;
    logic         valid_next;
    logic         load;
    result_item_t res_reg;

    assign load    = !valid_reg || out_ready;
    assign advance = evt_valid && load;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = evt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: sv/twi_slave_transaction_controller.sv
// ----------------------------------------------------------------------------
// twi_slave_transaction_controller
// Path: an event transaction that is taken is held in the input register,
// then its result in the result register. Throughput: one event per cycle,
// limited only by the result register draining on m_tready.
// Reset: synchronous on aresetn low; counters, status, mode and rx_capacity
// clear to zero (ready, result unknown, slave idle); both stages empty.
// ----------------------------------------------------------------------------
module twi_slave_transaction_controller
    import twi_stc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // bus_error, addr_or_stop, addr_match, data_event, collision,
    // master_reads, master_nacked, clock_held, tx_length[15:8]
    input  logic [InDataWidth-1:0]  s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // bus_command[1:0], clear_addr_flag, buffer_index[10:3], rx_store,
    // tx_load, notify_receive, notify_count[21:14], busy_res,
    // result_code[25:23], mode[27:26], zero fill
    output logic [OutDataWidth-1:0] m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_we,
    input  logic [CountWidth-1:0]   cfg_wdata
);

    event_t       s_event;
    event_t       evt;
    logic         evt_valid;
    logic         advance;
    result_item_t res_comb;
    result_item_t res_q;

    always_comb begin
        s_event.bus_error     = s_tdata[0];
        s_event.addr_or_stop  = s_tdata[1];
        s_event.addr_match    = s_tdata[2];
        s_event.data_event    = s_tdata[3];
        s_event.collision     = s_tdata[4];
        s_event.master_reads  = s_tdata[5];
        s_event.master_nacked = s_tdata[6];
        s_event.clock_held    = s_tdata[7];
        s_event.tx_length     = s_tdata[15:8];
    end

    twi_stc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_event  (s_event),
        .in_ready  (s_tready),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    twi_stc_event_logic u_event_logic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .evt       (evt),
        .res       (res_comb)
    );

    twi_stc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (evt_valid),
        .res_in    (res_comb),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_q)
    );

    assign m_tdata = {4'b0000,
                      res_q.mode,
                      res_q.result_code,
                      res_q.busy_res,
                      res_q.notify_count,
                      res_q.notify_receive,
                      res_q.tx_load,
                      res_q.rx_store,
                      res_q.buffer_index,
                      res_q.clear_addr_flag,
                      res_q.bus_command};

endmodule
